[rtl/parat_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time functions for the pressure
// altitude range tracker. No dependencies.
package parat_pkg;

   localparam int FRAC_BITS_DEFAULT   = 20;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int PRESS_W     = 17;
   localparam int MIN_PRESS_W = 20;
   localparam int ALT_W       = 23;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 120;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic CSR_SEA_LEVEL_IDX = 1'b0;

   localparam logic [PRESS_W-1:0]          SEA_LEVEL_RESET = 17'd101325;
   localparam logic [PRESS_W-1:0]          PEAK_P_RESET    = 17'd0;
   localparam logic [MIN_PRESS_W-1:0]      FLOOR_P_RESET   = 20'd1000000;
   localparam logic signed [ALT_W-1:0]     CUR_H_RESET     = 23'sd0;
   localparam logic signed [ALT_W-1:0]     PEAK_H_RESET    = -23'sd10000;
   localparam logic signed [ALT_W-1:0]     FLOOR_H_RESET   = 23'sd200000;

   localparam logic signed [23:0] ALT_SCALE = 24'sd4430000;
   localparam int                 ALT_MAX   = 4194303;
   localparam int                 ALT_MIN   = -4194304;

   // 0.1903 in fixed point: (K_NUM * 2^F + K_ROUND) / K_DEN
   localparam longint unsigned K_NUM   = 1903;
   localparam longint unsigned K_ROUND = 5000;
   localparam longint unsigned K_DEN   = 10000;

   typedef struct packed {
      logic               accepted;
      logic [PRESS_W-1:0] pressure;
   } queue_item_type;

   typedef struct packed {
      logic                    accepted;
      logic [4:0]              update_mask;
      logic                    pressure_report;
      logic                    altitude_report;
      logic [PRESS_W-1:0]      max_pressure;
      logic [MIN_PRESS_W-1:0]  min_pressure;
      logic signed [ALT_W-1:0] cur_altitude;
      logic signed [ALT_W-1:0] max_altitude;
      logic signed [ALT_W-1:0] min_altitude;
   } result_type;

   function automatic logic [63:0] isqrt64(input logic [63:0] v);
      logic [31:0] res;
      logic [31:0] cand;
      res = '0;
      for (int b = 31; b >= 0; b--) begin
         cand = res | (32'd1 << b);
         if (({32'd0, cand} * {32'd0, cand}) <= v) begin
            res = cand;
         end
      end
      return {32'd0, res};
   endfunction

   // Root 2^(1/2^steps) scaled by 2^frac_bits, built by repeated floor square roots.
   function automatic logic [63:0] exp_root(input int frac_bits, input int steps);
      logic [63:0] root;
      root = 64'd2 << frac_bits;
      for (int k = 0; k < steps; k++) begin
         root = isqrt64(root << frac_bits);
      end
      return root;
   endfunction

endpackage

[rtl/parat_front.sv]
`timescale 1ns / 1ps
// Front end: accepts pressure transactions and tags each as accepted or rejected.
// Depends on parat_pkg.
module parat_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [parat_pkg::PRESS_W-1:0]   pressure,
   input  logic                            queue_full,
   output logic                            queue_push,
   output parat_pkg::queue_item_type       queue_item
);

   logic [parat_pkg::PRESS_W-1:0] last_p_ff;
   logic [parat_pkg::PRESS_W-1:0] last_p_in;
   logic                          take;

   assign req_tready = !queue_full;
   assign take       = req_tvalid && !queue_full;
   assign queue_push = take;

   always_comb begin
      queue_item.pressure = pressure;
      queue_item.accepted = (pressure != '0) && (pressure != last_p_ff);
      last_p_in           = last_p_ff;
      if (take && queue_item.accepted) begin
         last_p_in = pressure;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_p_ff <= '0;
      end else begin
         last_p_ff <= last_p_in;
      end
   end

endmodule

[rtl/parat_fifo.sv]
`timescale 1ns / 1ps
// Small queue of classified samples between front and back end.
// Depends on parat_pkg.
module parat_fifo #(
   parameter int DEPTH = parat_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  parat_pkg::queue_item_type push_item,
   output logic                      full,
   input  logic                      pop,
   output logic                      valid,
   output parat_pkg::queue_item_type pop_item
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   parat_pkg::queue_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[rtl/parat_alt_engine.sv]
`timescale 1ns / 1ps
// Iterative altitude engine: ratio divide, log2, scale by 0.1903, exp2, final scaling.
// Depends on parat_pkg.
module parat_alt_engine #(
   parameter int FRAC_BITS = parat_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [parat_pkg::PRESS_W-1:0]        pressure,
   input  logic [parat_pkg::PRESS_W-1:0]        sea_level,
   output logic                                 done,
   output logic signed [parat_pkg::ALT_W-1:0]   altitude
);

   localparam int F  = FRAC_BITS;
   localparam int CW = $clog2(F + 1);
   localparam int IW = $clog2(F);
   localparam int EW = $clog2(F + 1);
   localparam int LW = F + EW + 1;
   localparam int PW = LW + F + 1;
   localparam int DW = F + 2;
   localparam int SW = DW + 24;
   localparam int AW = SW - F;

   localparam longint unsigned K_FULL =
      ((parat_pkg::K_NUM << F) + parat_pkg::K_ROUND) / parat_pkg::K_DEN;
   localparam logic [F-1:0]  K_COEF     = K_FULL[F-1:0];
   localparam logic [DW-1:0] ONE_W      = DW'(1) << F;
   localparam logic [SW-1:0] ROUND_BIAS = {{(SW - F){1'b0}}, {F{1'b1}}};

   typedef enum logic [9:0] {
      E_IDLE  = 10'b0000000001,
      E_DIV   = 10'b0000000010,
      E_NORM  = 10'b0000000100,
      E_LOG   = 10'b0000001000,
      E_MULK  = 10'b0000010000,
      E_SPLIT = 10'b0000100000,
      E_EXP   = 10'b0001000000,
      E_DIFF  = 10'b0010000000,
      E_SCALE = 10'b0100000000,
      E_FINAL = 10'b1000000000
   } eng_state_type;

   eng_state_type          state_ff, state_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [17:0]            rem_ff, rem_in;
   logic [F:0]             y_ff, y_in;
   logic [EW-1:0]          e_ff, e_in;
   logic [F-1:0]           frac_ff, frac_in;
   logic signed [PW-1:0]   prodk_ff, prodk_in;
   logic [F-1:0]           f_ff, f_in;
   logic [EW:0]            sh_ff, sh_in;
   logic [F:0]             acc_ff, acc_in;
   logic signed [DW-1:0]   d_ff, d_in;
   logic signed [SW-1:0]   sprod_ff, sprod_in;

   logic [F:0]             root_tab [F];
   logic                   sat;
   logic                   div_ge;
   logic [17:0]            div_rem;
   logic [F:0]             div_q;
   logic [2*F+1:0]         sq;
   logic [F+1:0]           ys;
   logic [EW:0]            neg_e;
   logic signed [LW-1:0]   log_val;
   logic signed [PW-1:0]   prodk_calc;
   logic signed [LW-1:0]   t_val;
   logic [EW:0]            n_val;
   logic [F:0]             root;
   logic [2*F+1:0]         mp;
   logic [F:0]             v_val;
   logic [DW-1:0]          diff;
   logic signed [SW-1:0]   sprod_calc;
   logic [SW-1:0]          rounded;
   logic signed [AW-1:0]   a_val;

   for (genvar gi = 0; gi < F; gi++) begin : g_root
      localparam logic [63:0] RV = parat_pkg::exp_root(F, gi + 1);
      assign root_tab[gi] = RV[F:0];
   end

   assign sat     = (sea_level == '0) || ({1'b0, pressure} >= {sea_level, 1'b0});
   assign div_ge  = rem_ff >= {1'b0, sea_level};
   assign div_rem = div_ge ? rem_ff - {1'b0, sea_level} : rem_ff;
   assign div_q   = {y_ff[F-1:0], div_ge};

   assign sq = {{(F + 1){1'b0}}, y_ff} * {{(F + 1){1'b0}}, y_ff};
   assign ys = sq[2*F+1:F];

   assign neg_e      = (EW + 1)'(~{1'b0, e_ff} + 1'b1);
   assign log_val    = {neg_e, frac_ff};
   assign prodk_calc = log_val * $signed({1'b0, K_COEF});
   assign t_val      = prodk_ff[F +: LW];
   assign n_val      = t_val[LW-1:F];

   assign root = root_tab[cnt_ff[IW-1:0]];
   assign mp   = {{(F + 1){1'b0}}, acc_ff} * {{(F + 1){1'b0}}, root};

   assign v_val      = acc_ff >> sh_ff;
   assign diff       = ONE_W - {1'b0, v_val};
   assign sprod_calc = d_ff * parat_pkg::ALT_SCALE;

   // truncate toward zero before dropping the fraction
   assign rounded = sprod_ff + (sprod_ff[SW-1] ? ROUND_BIAS : SW'(0));
   assign a_val   = rounded[SW-1:F];

   always_comb begin
      if (a_val > parat_pkg::ALT_MAX) begin
         altitude = parat_pkg::ALT_W'(parat_pkg::ALT_MAX);
      end else if (a_val < parat_pkg::ALT_MIN) begin
         altitude = parat_pkg::ALT_W'(parat_pkg::ALT_MIN);
      end else begin
         altitude = a_val[parat_pkg::ALT_W-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      rem_in   = rem_ff;
      y_in     = y_ff;
      e_in     = e_ff;
      frac_in  = frac_ff;
      prodk_in = prodk_ff;
      f_in     = f_ff;
      sh_in    = sh_ff;
      acc_in   = acc_ff;
      d_in     = d_ff;
      sprod_in = sprod_ff;
      done     = 1'b0;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               cnt_in = '0;
               e_in   = '0;
               if (sat) begin
                  y_in     = '1;
                  state_in = E_NORM;
               end else begin
                  y_in     = '0;
                  rem_in   = {1'b0, pressure};
                  state_in = E_DIV;
               end
            end
         end
         E_DIV: begin
            rem_in = {div_rem[16:0], 1'b0};
            y_in   = div_q;
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(F)) begin
               if (div_q == '0) begin
                  y_in = (F + 1)'(1);
               end
               state_in = E_NORM;
            end
         end
         E_NORM: begin
            if (y_ff[F]) begin
               cnt_in   = '0;
               frac_in  = '0;
               state_in = E_LOG;
            end else begin
               y_in = {y_ff[F-1:0], 1'b0};
               e_in = e_ff + 1'b1;
            end
         end
         E_LOG: begin
            frac_in = {frac_ff[F-2:0], ys[F+1]};
            y_in    = ys[F+1] ? ys[F+1:1] : ys[F:0];
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CW'(F - 1)) begin
               state_in = E_MULK;
            end
         end
         E_MULK: begin
            prodk_in = prodk_calc;
            state_in = E_SPLIT;
         end
         E_SPLIT: begin
            f_in     = t_val[F-1:0];
            sh_in    = (EW + 1)'(~n_val + 1'b1);
            acc_in   = (F + 1)'(1) << F;
            cnt_in   = '0;
            state_in = E_EXP;
         end
         E_EXP: begin
            if (f_ff[F-1]) begin
               acc_in = mp[2*F:F];
            end
            f_in   = {f_ff[F-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CW'(F - 1)) begin
               state_in = E_DIFF;
            end
         end
         E_DIFF: begin
            d_in     = diff;
            state_in = E_SCALE;
         end
         E_SCALE: begin
            sprod_in = sprod_calc;
            state_in = E_FINAL;
         end
         E_FINAL: begin
            done     = 1'b1;
            state_in = E_IDLE;
         end
         default: begin
            state_in = E_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      rem_ff   <= rem_in;
      y_ff     <= y_in;
      e_ff     <= e_in;
      frac_ff  <= frac_in;
      prodk_ff <= prodk_in;
      f_ff     <= f_in;
      sh_ff    <= sh_in;
      acc_ff   <= acc_in;
      d_ff     <= d_in;
      sprod_ff <= sprod_in;
   end

endmodule

[rtl/parat_back.sv]
`timescale 1ns / 1ps
// Back end: runs the altitude engine, updates tracked extremes, holds the result register.
// Depends on parat_pkg and parat_alt_engine.
module parat_back #(
   parameter int FRAC_BITS = parat_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            queue_valid,
   input  parat_pkg::queue_item_type       queue_item,
   output logic                            queue_pop,
   input  logic [parat_pkg::PRESS_W-1:0]   sea_level,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output parat_pkg::result_type           result
);

   localparam int AW = parat_pkg::ALT_W;

   typedef enum logic [2:0] {
      B_IDLE = 3'b001,
      B_CALC = 3'b010,
      B_HOLD = 3'b100
   } back_state_type;

   back_state_type                     bstate_ff, bstate_in;
   logic [parat_pkg::PRESS_W-1:0]      p_ff, p_in;
   logic signed [AW-1:0]               alt_ff, alt_in;
   logic [parat_pkg::PRESS_W-1:0]      peak_p_ff, peak_p_in;
   logic [parat_pkg::MIN_PRESS_W-1:0]  floor_p_ff, floor_p_in;
   logic signed [AW-1:0]               cur_h_ff, cur_h_in;
   logic signed [AW-1:0]               peak_h_ff, peak_h_in;
   logic signed [AW-1:0]               floor_h_ff, floor_h_in;
   logic                               out_valid_ff, out_valid_in;
   parat_pkg::result_type              out_ff, out_in;

   logic                 eng_start;
   logic                 eng_done;
   logic signed [AW-1:0] eng_alt;
   logic                 slot_free;
   logic                 load;
   logic                 upd;
   logic [4:0]           mask;

   parat_alt_engine #(
      .FRAC_BITS (FRAC_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (eng_start),
      .pressure  (queue_item.pressure),
      .sea_level (sea_level),
      .done      (eng_done),
      .altitude  (eng_alt)
   );

   assign slot_free  = !out_valid_ff || rsp_tready;
   assign rsp_tvalid = out_valid_ff;
   assign result     = out_ff;

   always_comb begin
      mask[0] = p_ff > peak_p_ff;
      mask[1] = {3'b000, p_ff} < floor_p_ff;
      mask[2] = alt_ff != cur_h_ff;
      mask[3] = alt_ff > peak_h_ff;
      mask[4] = alt_ff < floor_h_ff;
   end

   always_comb begin
      bstate_in = bstate_ff;
      p_in      = p_ff;
      alt_in    = alt_ff;
      queue_pop = 1'b0;
      eng_start = 1'b0;
      load      = 1'b0;
      upd       = 1'b0;
      unique case (bstate_ff)
         B_IDLE: begin
            if (queue_valid) begin
               if (queue_item.accepted) begin
                  queue_pop = 1'b1;
                  eng_start = 1'b1;
                  p_in      = queue_item.pressure;
                  bstate_in = B_CALC;
               end else if (slot_free) begin
                  queue_pop = 1'b1;
                  load      = 1'b1;
               end
            end
         end
         B_CALC: begin
            if (eng_done) begin
               alt_in    = eng_alt;
               bstate_in = B_HOLD;
            end
         end
         B_HOLD: begin
            if (slot_free) begin
               load      = 1'b1;
               upd       = 1'b1;
               bstate_in = B_IDLE;
            end
         end
         default: begin
            bstate_in = B_IDLE;
         end
      endcase
   end

   always_comb begin
      peak_p_in  = (upd && mask[0]) ? p_ff : peak_p_ff;
      floor_p_in = (upd && mask[1]) ? {3'b000, p_ff} : floor_p_ff;
      cur_h_in   = (upd && mask[2]) ? alt_ff : cur_h_ff;
      peak_h_in  = (upd && mask[3]) ? alt_ff : peak_h_ff;
      floor_h_in = (upd && mask[4]) ? alt_ff : floor_h_ff;

      out_in                 = out_ff;
      out_valid_in           = rsp_tready ? 1'b0 : out_valid_ff;
      if (load) begin
         out_valid_in           = 1'b1;
         out_in.accepted        = upd;
         out_in.update_mask     = upd ? mask : 5'b00000;
         out_in.pressure_report = upd && (mask[1:0] != 2'b00);
         out_in.altitude_report = upd && (mask[4:2] != 3'b000);
         out_in.max_pressure    = peak_p_in;
         out_in.min_pressure    = floor_p_in;
         out_in.cur_altitude    = cur_h_in;
         out_in.max_altitude    = peak_h_in;
         out_in.min_altitude    = floor_h_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bstate_ff    <= B_IDLE;
         peak_p_ff    <= parat_pkg::PEAK_P_RESET;
         floor_p_ff   <= parat_pkg::FLOOR_P_RESET;
         cur_h_ff     <= parat_pkg::CUR_H_RESET;
         peak_h_ff    <= parat_pkg::PEAK_H_RESET;
         floor_h_ff   <= parat_pkg::FLOOR_H_RESET;
         out_valid_ff <= 1'b0;
      end else begin
         bstate_ff    <= bstate_in;
         peak_p_ff    <= peak_p_in;
         floor_p_ff   <= floor_p_in;
         cur_h_ff     <= cur_h_in;
         peak_h_ff    <= peak_h_in;
         floor_h_ff   <= floor_h_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      alt_ff <= alt_in;
      out_ff <= out_in;
   end

   a_done_in_calc: assert property (@(posedge clock) disable iff (reset)
      eng_done |-> bstate_ff == B_CALC)
      else $error("engine finished outside of calculation");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> queue_valid)
      else $error("queue popped while empty");

   a_reject_no_mask: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_ff.accepted |-> out_ff.update_mask == 5'b00000)
      else $error("rejected transaction carries an update mask");

   a_peak_floor: assert property (@(posedge clock) disable iff (reset)
      peak_h_ff >= parat_pkg::PEAK_H_RESET)
      else $error("peak altitude dropped below its reset value");

endmodule

[rtl/pressure_altitude_range_tracker_unit.sv]
`timescale 1ns / 1ps
// Top level of the pressure altitude range tracker: CSR port, front end, queue, back end.
// Depends on parat_pkg, parat_front, parat_fifo and parat_back.

// Takes one barometric pressure sample per transaction and returns one result per
// sample, in order. Zero samples and repeats of the last accepted sample pass through
// the queue and are loaded into the result register when the back end is free, with
// the tracked values unchanged. An accepted sample runs through a single iterative
// altitude engine: a restoring divide for the ratio (skipped when the ratio saturates),
// normalization, FRAC_BITS squaring steps for log2, FRAC_BITS root-multiply steps for
// exp2 and five fixed steps; it also passes through the queue, the engine start and
// the update of the tracked values. Any wait for the back end or the response side
// adds to the time from acceptance to a valid response. The engine handles one sample
// at a time; a short queue lets the input side keep accepting while it works.
// sea_level_pressure lives at byte address 0 of the CSR port and should only be
// written while the block is idle.
module pressure_altitude_range_tracker_unit #(
   parameter int FRAC_BITS   = parat_pkg::FRAC_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = parat_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: pressure_pa[16:0], zero pad [23:17]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [parat_pkg::REQ_DATA_W-1:0]    req_tdata,
   // rsp_tdata: accepted[0], update_mask[5:1], pressure_report[6], altitude_report[7],
   // max_pressure[24:8], min_pressure[44:25], cur_altitude[67:45],
   // max_altitude[90:68], min_altitude[113:91], zero pad [119:114]
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [parat_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [parat_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [parat_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [parat_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                csr_pready
);

   logic [parat_pkg::PRESS_W-1:0] sea_level_ff, sea_level_in;
   logic                          csr_write;

   logic                      q_push;
   logic                      q_full;
   logic                      q_pop;
   logic                      q_valid;
   parat_pkg::queue_item_type q_push_item;
   parat_pkg::queue_item_type q_pop_item;
   parat_pkg::result_type     result;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      sea_level_in = sea_level_ff;
      if (csr_write && (csr_paddr[2] == parat_pkg::CSR_SEA_LEVEL_IDX)) begin
         sea_level_in = csr_pwdata[parat_pkg::PRESS_W-1:0];
      end
      if (csr_paddr[2] == parat_pkg::CSR_SEA_LEVEL_IDX) begin
         csr_prdata = {{(parat_pkg::CSR_DATA_W - parat_pkg::PRESS_W){1'b0}}, sea_level_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sea_level_ff <= parat_pkg::SEA_LEVEL_RESET;
      end else begin
         sea_level_ff <= sea_level_in;
      end
   end

   parat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .pressure   (req_tdata[parat_pkg::PRESS_W-1:0]),
      .queue_full (q_full),
      .queue_push (q_push),
      .queue_item (q_push_item)
   );

   parat_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (q_pop_item)
   );

   parat_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (q_valid),
      .queue_item  (q_pop_item),
      .queue_pop   (q_pop),
      .sea_level   (sea_level_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .result      (result)
   );

   assign rsp_tdata = {6'b000000,
                       result.min_altitude,
                       result.max_altitude,
                       result.cur_altitude,
                       result.min_pressure,
                       result.max_pressure,
                       result.altitude_report,
                       result.pressure_report,
                       result.update_mask,
                       result.accepted};

endmodule
